// ----- rtl/row_short_run_filter_core_assert.svh -----
// Assertion macros for the filter RTL, included by rsrf_ctrl.
// RSRF_ASSERT checks a property on the clock with reset gating.
// RSRF_ASSERT_ALWAYS checks a property on the clock, also during reset.
`ifndef ROW_SHORT_RUN_FILTER_CORE_ASSERT_SVH
`define ROW_SHORT_RUN_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define RSRF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

`define RSRF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define RSRF_ASSERT(lbl, clk, rstn, prop)

`define RSRF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/rsrf_pkg.sv -----
package rsrf_pkg;

    // Delay line geometry
    localparam int DELAY_DEPTH = 128;
    localparam int IDX_W       = $clog2(DELAY_DEPTH);
    localparam int OCC_W       = $clog2(DELAY_DEPTH + 1);
    localparam int RUN_W       = 8;
    localparam int CNT_W       = (IDX_W > RUN_W) ? IDX_W : RUN_W;

    // Register widths and limits
    localparam int ROW_W    = 13;
    localparam int BORDER_W = 12;
    localparam int MINRUN_W = 8;
    localparam int CFG_W    = 13;

    localparam logic [ROW_W-1:0]    ROW_WIDTH_RESET   = 13'd640;
    localparam logic [ROW_W-1:0]    ROW_WIDTH_MAX     = 13'd4096;
    localparam logic [BORDER_W-1:0] BORDER_COLS_RESET = 12'd6;
    localparam logic [MINRUN_W-1:0] MIN_RUN_RESET     = 8'd80;
    localparam logic [RUN_W-1:0]    RUN_MAX           = 8'd255;

    // Register indexes
    localparam logic [1:0] CFG_ROW_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_BORDER_COLS = 2'd1;
    localparam logic [1:0] CFG_MIN_RUN     = 2'd2;

    // Input item kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // One held pixel
    typedef struct packed {
        logic row_end;
        logic white;
    } entry_t;

    // Broadcast from the control to every cell
    typedef struct packed {
        logic             pop;
        logic             push;
        logic [IDX_W-1:0] push_idx;
        logic             clear_en;
        logic [IDX_W-1:0] clear_lo;
        entry_t           new_entry;
    } cell_ctrl_t;

endpackage

// ----- rtl/rsrf_cell.sv -----
module rsrf_cell
    import rsrf_pkg::*;
(
    input  logic             aclk,
    input  logic [IDX_W-1:0] cell_idx,
    input  cell_ctrl_t       ctrl,
    input  entry_t           nbr_data,
    output entry_t           data
);

    entry_t data_reg;
    entry_t data_next;

    // Shift toward the output on pop, take the new beat at the tail,
    // then erase the white bit if this cell lies in the short run
    always_comb begin
        data_next = ctrl.pop ? nbr_data : data_reg;
        if (ctrl.push && (cell_idx == ctrl.push_idx)) begin
            data_next = ctrl.new_entry;
        end
        if (ctrl.clear_en && (cell_idx >= ctrl.clear_lo)) begin
            data_next.white = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/rsrf_ctrl.sv -----
module rsrf_ctrl
    import rsrf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic             op,
    input  logic             pixel_white,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cell_ctrl_t       ctrl
);

`include "row_short_run_filter_core_assert.svh"

    logic [ROW_W-1:0]    row_width_reg;
    logic [BORDER_W-1:0] border_cols_reg;
    logic [MINRUN_W-1:0] min_run_reg;

    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [BORDER_W-1:0] col_reg, col_next;
    logic [RUN_W-1:0]    run_reg, run_next;

    logic [ROW_W-1:0]    eff_width;
    logic [ROW_W-1:0]    col_ext;
    logic                border;
    logic                row_end;
    logic                white_eff;
    logic                full;
    logic                empty;
    logic                pop;
    logic                push;
    logic [IDX_W-1:0]    post_occ;
    logic [CNT_W-1:0]    post_w;
    logic [CNT_W-1:0]    run_w;
    logic [CNT_W-1:0]    clr_cnt;
    logic                clear_en;
    logic [IDX_W-1:0]    clear_lo;

    // Clamp row width to its legal range
    always_comb begin
        if (row_width_reg == '0) begin
            eff_width = ROW_W'(1);
        end else if (row_width_reg > ROW_WIDTH_MAX) begin
            eff_width = ROW_WIDTH_MAX;
        end else begin
            eff_width = row_width_reg;
        end
    end

    // Classify the current column
    assign col_ext   = {1'b0, col_reg};
    assign border    = (col_reg < border_cols_reg)
                     || ((col_ext + {1'b0, border_cols_reg}) >= eff_width);
    assign row_end   = (col_ext + ROW_W'(1)) >= eff_width;
    assign white_eff = pixel_white & ~border;

    // Decide pop and push for this beat
    assign full  = (occ_reg == OCC_W'(DELAY_DEPTH));
    assign empty = (occ_reg == '0);
    assign push  = accept && (op == OP_PIXEL);
    assign pop   = accept && ((op == OP_FLUSH) ? !empty : full);

    // Entries held besides the new one, after any pop
    assign post_occ = full ? IDX_W'(DELAY_DEPTH - 1) : occ_reg[IDX_W-1:0];

    // Find the lowest cell of a short run ended by this black pixel
    assign post_w   = CNT_W'(post_occ);
    assign run_w    = CNT_W'(run_reg);
    assign clr_cnt  = (run_w < post_w) ? run_w : post_w;
    assign clear_lo = IDX_W'(post_w - clr_cnt);
    assign clear_en = push && !white_eff && (run_reg != '0)
                    && (run_reg < min_run_reg);

    // Advance occupancy, column and run length
    always_comb begin
        occ_next = occ_reg;
        col_next = col_reg;
        run_next = run_reg;
        if (push && !pop) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (pop && !push) begin
            occ_next = occ_reg - OCC_W'(1);
        end
        if (push) begin
            if (row_end) begin
                col_next = '0;
                run_next = '0;
            end else begin
                col_next = col_reg + BORDER_W'(1);
                if (white_eff) begin
                    run_next = (run_reg == RUN_MAX) ? run_reg : run_reg + RUN_W'(1);
                end else begin
                    run_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg         <= '0;
            col_reg         <= '0;
            run_reg         <= '0;
            row_width_reg   <= ROW_WIDTH_RESET;
            border_cols_reg <= BORDER_COLS_RESET;
            min_run_reg     <= MIN_RUN_RESET;
        end else begin
            occ_reg <= occ_next;
            col_reg <= col_next;
            run_reg <= run_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROW_WIDTH:   row_width_reg   <= cfg_data;
                    CFG_BORDER_COLS: border_cols_reg <= cfg_data[BORDER_W-1:0];
                    CFG_MIN_RUN:     min_run_reg     <= cfg_data[MINRUN_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // Drive the cell broadcast
    always_comb begin
        ctrl.pop               = pop;
        ctrl.push              = push;
        ctrl.push_idx          = post_occ;
        ctrl.clear_en          = clear_en;
        ctrl.clear_lo          = clear_lo;
        ctrl.new_entry.row_end = row_end;
        ctrl.new_entry.white   = white_eff;
    end

    // Occupancy stays within the line, pops only from a non-empty line,
    // a full line always pops on push, erasure never reaches past the tail
    `RSRF_ASSERT(a_occ_bound, aclk, aresetn, occ_reg <= OCC_W'(DELAY_DEPTH))
    `RSRF_ASSERT(a_pop_nonempty, aclk, aresetn, pop |-> (occ_reg != '0))
    `RSRF_ASSERT(a_full_push_pops, aclk, aresetn, (push && full) |-> pop)
    `RSRF_ASSERT(a_clear_range, aclk, aresetn, clear_en |-> (clear_lo <= post_occ))

endmodule

// ----- rtl/row_short_run_filter_core.sv -----
// Horizontal short-run filter on a binary pixel stream.
// Throughput: one beat per cycle on the input, one beat per cycle on the output, while the sink keeps m_tready high.
// Latency: a pixel leaves when DELAY_DEPTH later pixels have entered, or on flush;
// the output register presents it in the cycle after the popping beat.
// Reset (synchronous, aresetn low) empties the cell chain, clears column and
// run length, and restores the register defaults; cell payloads are not cleared.
module row_short_run_filter_core
    import rsrf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] pixel_white, [7:1] zero
    input  logic [0:0]       s_tuser,   // [0] op
    // Result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [0] pixel_out, [7:1] zero
    output logic             m_tlast,
    // Configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cell_ctrl_t ctrl;
    entry_t     cell_data [DELAY_DEPTH+1];
    logic       accept;

    logic       m_valid_reg, m_valid_next;
    logic       m_pix_reg;
    logic       m_last_reg;

    // Take a beat whenever the output slot is free this cycle
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    rsrf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .op          (s_tuser[0]),
        .pixel_white (s_tdata[0]),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ctrl        (ctrl)
    );

    // Chain of cells, cell 0 holds the oldest pixel
    assign cell_data[DELAY_DEPTH] = '0;

    for (genvar i = 0; i < DELAY_DEPTH; i++) begin : g_cell
        rsrf_cell u_cell (
            .aclk     (aclk),
            .cell_idx (IDX_W'(i)),
            .ctrl     (ctrl),
            .nbr_data (cell_data[i+1]),
            .data     (cell_data[i])
        );
    end

    // Hold the popped pixel until the sink takes it
    assign m_valid_next = ctrl.pop ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.pop) begin
            m_pix_reg  <= cell_data[0].white;
            m_last_reg <= cell_data[0].row_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_pix_reg};
    assign m_tlast  = m_last_reg;

endmodule
